// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg - texture coordinate wrap shared types and constants
// Item layouts, address modes, register indexes and per-lane stage records.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int MAX_SIZE  = 16384;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int INT_W     = COORD_W - FRAC_BITS;
    localparam int SIZE_W    = 15;
    localparam int TEXEL_W   = 16;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;
    localparam int PROD_W    = FRAC_BITS + SIZE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSIONS = 3'd0,
        CFG_SIZE_U     = 3'd1,
        CFG_SIZE_V     = 3'd2,
        CFG_SIZE_W     = 3'd3,
        CFG_MODE_U     = 3'd4,
        CFG_MODE_V     = 3'd5,
        CFG_MODE_W     = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_REPEAT      = 3'd0,
        MODE_MIRROR      = 3'd1,
        MODE_EDGE        = 3'd2,
        MODE_BORDER      = 3'd3,
        MODE_MIRROR_EDGE = 3'd4
    } mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
        logic signed [COORD_W-1:0] coord_w;
    } coord_item_t;

    typedef struct packed {
        logic signed [TEXEL_W-1:0] texel_u;
        logic signed [TEXEL_W-1:0] texel_v;
        logic signed [TEXEL_W-1:0] texel_w;
        logic                      use_border;
    } texel_item_t;

    // Axis enable and integer part classes of the coordinate; the classes decide every clamp.
    typedef struct packed {
        logic en;
        logic q_zero;
        logic q_neg;
        logic q_minus1;
        logic q_odd;
    } lane_ctl_t;

    typedef struct packed {
        lane_ctl_t           ctl;
        mode_t               mode;
        logic [SIZE_W-1:0]   size;
        logic [FRAC_BITS-1:0] frac;
    } lane_s1_t;

    typedef struct packed {
        lane_ctl_t         ctl;
        mode_t             mode;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] idx;
    } lane_s2_t;

    function automatic mode_t decode_mode(input logic [2:0] raw);
        mode_t m;
        case (raw)
            MODE_REPEAT:      m = MODE_REPEAT;
            MODE_MIRROR:      m = MODE_MIRROR;
            MODE_BORDER:      m = MODE_BORDER;
            MODE_MIRROR_EDGE: m = MODE_MIRROR_EDGE;
            default:          m = MODE_EDGE;
        endcase
        return m;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] s;
        if (raw == '0)
            s = SIZE_W'(1);
        else if (raw > SIZE_W'(MAX_SIZE))
            s = SIZE_W'(MAX_SIZE);
        else
            s = raw;
        return s;
    endfunction

endpackage

// ===== rtl/texture_coordinate_wrap.sv =====
// ----------------------------------------------------------------------------
// texture_coordinate_wrap - texel address unit for nearest filtering
// Throughput: one item per cycle unless the output stalls; three register stages
// (decode, multiply, wrap select) move with valid bits and hold under output stall.
// Reset clears the stage valid bits and loads the register defaults
// (dimensions 2, sizes 1, modes clamp to edge); no clearing pass.
// ----------------------------------------------------------------------------
module texture_coordinate_wrap
    import tcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 coord_valid,
    output logic                 coord_stall,
    input  coord_item_t          coord,
    output logic                 texel_valid,
    input  logic                 texel_stall,
    output texel_item_t          texel
);

    logic [1:0]        dimensions_reg;
    logic [SIZE_W-1:0] size_reg [NUM_AXES];
    logic [2:0]        mode_reg [NUM_AXES];

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        texel_valid_reg;
    lane_s1_t    s1_reg   [NUM_AXES];
    lane_s1_t    s1_next  [NUM_AXES];
    lane_s2_t    s2_reg   [NUM_AXES];
    lane_s2_t    s2_next  [NUM_AXES];
    texel_item_t texel_reg;
    texel_item_t texel_next;

    logic ready3;
    logic ready2;
    logic ready1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimensions_reg <= 2'd2;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                size_reg[a] <= SIZE_W'(1);
                mode_reg[a] <= MODE_EDGE;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DIMENSIONS: dimensions_reg <= cfg_data[1:0];
                CFG_SIZE_U:     size_reg[0]    <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_V:     size_reg[1]    <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_W:     size_reg[2]    <= cfg_data[SIZE_W-1:0];
                CFG_MODE_U:     mode_reg[0]    <= cfg_data[2:0];
                CFG_MODE_V:     mode_reg[1]    <= cfg_data[2:0];
                CFG_MODE_W:     mode_reg[2]    <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads if empty or if the next one can take an item
    // ------------------------------------------------------------------
    assign ready3      = !texel_valid_reg || !texel_stall;
    assign ready2      = !s2_valid_reg || ready3;
    assign ready1      = !s1_valid_reg || ready2;
    assign coord_stall = !ready1;

    // ------------------------------------------------------------------
    // Stage 1: split coordinate, classify integer part, latch axis setup
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [COORD_W-1:0] c [NUM_AXES];
        logic [INT_W-1:0]          q;
        logic [NUM_AXES-1:0]       en;
        c[0]  = coord.coord_u;
        c[1]  = coord.coord_v;
        c[2]  = coord.coord_w;
        en[0] = 1'b1;
        en[1] = (dimensions_reg >= 2'd2);
        en[2] = (dimensions_reg == 2'd3);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            q                     = c[a][COORD_W-1:FRAC_BITS];
            s1_next[a].ctl.en       = en[a];
            s1_next[a].ctl.q_zero   = (q == '0);
            s1_next[a].ctl.q_neg    = q[INT_W-1];
            s1_next[a].ctl.q_minus1 = &q;
            s1_next[a].ctl.q_odd    = q[0];
            s1_next[a].mode         = decode_mode(mode_reg[a]);
            s1_next[a].size         = sat_size(size_reg[a]);
            s1_next[a].frac         = c[a][FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: index within one period = floor(frac * size / 2^FRAC_BITS)
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            prod            = PROD_W'(s1_reg[a].frac) * PROD_W'(s1_reg[a].size);
            s2_next[a].ctl  = s1_reg[a].ctl;
            s2_next[a].mode = s1_reg[a].mode;
            s2_next[a].size = s1_reg[a].size;
            s2_next[a].idx  = prod[PROD_W-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: apply the address mode per axis
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [TEXEL_W-1:0] r [NUM_AXES];
        logic signed [TEXEL_W-1:0] idx;
        logic signed [TEXEL_W-1:0] last;
        logic signed [TEXEL_W-1:0] flip;
        logic signed [TEXEL_W-1:0] sz;
        logic                      border;
        border = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            idx  = TEXEL_W'(s2_reg[a].idx);
            sz   = TEXEL_W'(s2_reg[a].size);
            last = sz - TEXEL_W'(1);
            flip = last - idx;
            case (s2_reg[a].mode)
                MODE_REPEAT:
                    r[a] = idx;
                MODE_MIRROR:
                    r[a] = s2_reg[a].ctl.q_odd ? flip : idx;
                MODE_BORDER:
                begin
                    if (s2_reg[a].ctl.q_zero)
                        r[a] = idx;
                    else if (s2_reg[a].ctl.q_neg)
                        r[a] = '1;
                    else
                        r[a] = sz;
                    if (s2_reg[a].ctl.en && !s2_reg[a].ctl.q_zero)
                        border = 1'b1;
                end
                MODE_MIRROR_EDGE:
                begin
                    if (s2_reg[a].ctl.q_zero)
                        r[a] = idx;
                    else if (s2_reg[a].ctl.q_minus1)
                        r[a] = flip;
                    else
                        r[a] = last;
                end
                default:
                begin
                    if (s2_reg[a].ctl.q_zero)
                        r[a] = idx;
                    else if (s2_reg[a].ctl.q_neg)
                        r[a] = '0;
                    else
                        r[a] = last;
                end
            endcase
            // unused axis reads as zero
            if (!s2_reg[a].ctl.en)
                r[a] = '0;
        end
        texel_next.texel_u    = r[0];
        texel_next.texel_v    = r[1];
        texel_next.texel_w    = r[2];
        texel_next.use_border = border;
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            texel_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= coord_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                texel_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && coord_valid)
            s1_reg <= s1_next;
        if (ready2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (ready3 && s2_valid_reg)
            texel_reg <= texel_next;
    end

    assign texel_valid = texel_valid_reg;
    assign texel       = texel_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> (s1_valid_reg && s2_valid_reg && texel_valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    a_negative_needs_border: assert property (@(posedge clk) disable iff (!rst_n)
        (texel_valid_reg && (texel_reg.texel_u < 0 || texel_reg.texel_v < 0
                             || texel_reg.texel_w < 0)) |-> texel_reg.use_border)
        else $error("negative texel index without border flag");

    a_unused_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ready3 && s2_valid_reg && !s2_reg[2].ctl.en) |=> (texel_reg.texel_w == '0))
        else $error("unused third axis gave a nonzero index");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        texel_valid_reg |-> (texel_reg.texel_u <= MAX_SIZE && texel_reg.texel_v <= MAX_SIZE
                             && texel_reg.texel_w <= MAX_SIZE))
        else $error("texel index beyond the largest size");

endmodule
